// File: design/mogd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the motor overload derate guard.
package mogd_pkg;

  localparam int unsigned CurWidth   = 15;
  localparam int unsigned MaxCurWidth = 14;
  localparam int unsigned TempWidth  = 12;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned SpeedWidth = 16;
  localparam int unsigned RunWidth   = 10;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 14;

  localparam logic [RunWidth-1:0] RUN_MAX = 10'd1023;

  // register reset values
  localparam logic [MaxCurWidth-1:0]      MAX_CUR_RST   = 14'd5000;
  localparam logic [CountWidth-1:0]       CUR_TRIP_RST  = 8'd10;
  localparam logic signed [TempWidth-1:0] MAX_TEMP_RST  = 12'sd700;
  localparam logic [CountWidth-1:0]       TEMP_TRIP_RST = 8'd10;

  // tier offsets below the current threshold, release margins
  localparam logic signed [16:0] TIER1_OFS   = 17'sd1000;
  localparam logic signed [16:0] TIER2_OFS   = 17'sd2000;
  localparam logic signed [16:0] CUR_REL_OFS = 17'sd2300;
  localparam logic signed [12:0] TEMP_REL_OFS = 13'sd150;

  // Q16 reciprocals of the derate divisors
  localparam logic [15:0] RECIP_HALF        = 16'd32768;
  localparam logic [15:0] RECIP_TWO_THIRDS  = 16'd43691;
  localparam logic [15:0] RECIP_FOUR_FIFTHS = 16'd52429;

  localparam logic [1:0] CMD_CURRENT = 2'd0;
  localparam logic [1:0] CMD_TEMP    = 2'd1;
  localparam logic [1:0] CMD_SPEED   = 2'd2;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HEAT   = 2'd1;
  localparam logic [1:0] MODE_DERATE = 2'd2;

  localparam logic [1:0] DERATE_DIV2   = 2'd0;
  localparam logic [1:0] DERATE_DIV1P5 = 2'd1;
  localparam logic [1:0] DERATE_DIV1P25 = 2'd2;

  localparam logic [CfgIdxWidth-1:0] REG_MAX_CURRENT = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_CUR_TRIP    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_TEMP    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_TEMP_TRIP   = 2'd3;

  typedef struct packed {
    logic [MaxCurWidth-1:0]      max_current_ma;
    logic [CountWidth-1:0]       current_trip_count;
    logic signed [TempWidth-1:0] max_temp_dc;
    logic [CountWidth-1:0]       temp_trip_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [CurWidth-1:0]   current_ma;
    logic signed [TempWidth-1:0]  temp_dc;
    logic signed [SpeedWidth-1:0] speed_request;
  } item_t;

  typedef struct packed {
    logic [RunWidth-1:0] current_run;
    logic [RunWidth-1:0] heat_run;
    logic                current_flag;
    logic                heat_flag;
    logic [1:0]          guard_mode;
    logic [1:0]          derate_code;
  } guard_state_t;

  typedef struct packed {
    logic [1:0]                   safe_state;
    logic                         current_alarm;
    logic                         heat_alarm;
    logic signed [SpeedWidth-1:0] speed_reference;
  } result_t;

endpackage

// File: design/mogd_eval.sv
`timescale 1ns / 1ps
// Single-pass evaluation of one transaction: next guard state and result.
module mogd_eval (
  input  mogd_pkg::cfg_t         cfg,
  input  mogd_pkg::item_t        item,
  input  mogd_pkg::guard_state_t cur,
  output mogd_pkg::guard_state_t nxt,
  output mogd_pkg::result_t      res
);
  import mogd_pkg::*;

  logic signed [16:0] c_ext;
  logic signed [16:0] m_ext;
  logic signed [12:0] t_ext;
  logic signed [12:0] tm_ext;
  logic [RunWidth-1:0] cur_bump;
  logic [RunWidth-1:0] heat_bump;
  logic [RunWidth-1:0] lim1;
  logic [RunWidth-1:0] lim2;
  logic [RunWidth-1:0] lim3;
  logic [15:0] recip;
  logic signed [32:0] prod;
  logic signed [SpeedWidth-1:0] speed;

  assign c_ext  = {{2{item.current_ma[CurWidth-1]}}, item.current_ma};
  assign m_ext  = {3'b000, cfg.max_current_ma};
  assign t_ext  = {item.temp_dc[TempWidth-1], item.temp_dc};
  assign tm_ext = {cfg.max_temp_dc[TempWidth-1], cfg.max_temp_dc};

  assign cur_bump  = (cur.current_run == RUN_MAX) ? RUN_MAX : cur.current_run + 10'd1;
  assign heat_bump = (cur.heat_run == RUN_MAX) ? RUN_MAX : cur.heat_run + 10'd1;

  assign lim1 = {2'b00, cfg.current_trip_count};
  assign lim2 = {1'b0, cfg.current_trip_count, 1'b0};
  assign lim3 = lim2 + lim1;

  always_comb begin
    unique case (cur.derate_code)
      DERATE_DIV1P5:  recip = RECIP_TWO_THIRDS;
      DERATE_DIV1P25: recip = RECIP_FOUR_FIFTHS;
      default:        recip = RECIP_HALF;
    endcase
  end

  // floor(req * recip / 2^16) is an arithmetic shift of the product
  assign prod = $signed({{17{item.speed_request[SpeedWidth-1]}}, item.speed_request}) *
                $signed({17'd0, recip});

  always_comb begin
    unique case (cur.guard_mode)
      MODE_HEAT:   speed = '0;
      MODE_DERATE: speed = prod[31:16];
      default:     speed = item.speed_request;
    endcase
  end

  always_comb begin
    nxt = cur;
    res.speed_reference = '0;
    unique case (item.command)
      CMD_CURRENT: begin
        priority if (c_ext > m_ext) begin
          nxt.current_run = cur_bump;
          if (cur_bump >= lim1) begin
            nxt.current_flag = 1'b1;
            nxt.guard_mode   = MODE_DERATE;
            nxt.derate_code  = DERATE_DIV2;
          end
        end else if (c_ext > m_ext - TIER1_OFS) begin
          nxt.current_run = cur_bump;
          if (cur_bump >= lim2) begin
            nxt.current_flag = 1'b1;
            nxt.guard_mode   = MODE_DERATE;
            nxt.derate_code  = DERATE_DIV1P5;
          end
        end else if (c_ext > m_ext - TIER2_OFS) begin
          nxt.current_run = cur_bump;
          if (cur_bump >= lim3) begin
            nxt.current_flag = 1'b1;
            nxt.guard_mode   = MODE_DERATE;
            nxt.derate_code  = DERATE_DIV1P25;
          end
        end else begin
          nxt.current_run = '0;
        end
        if (nxt.current_flag && (c_ext < m_ext - CUR_REL_OFS)) begin
          nxt.current_flag = 1'b0;
          nxt.guard_mode   = MODE_NORMAL;
        end
      end
      CMD_TEMP: begin
        if (t_ext > tm_ext) begin
          nxt.heat_run = heat_bump;
          if (heat_bump >= {2'b00, cfg.temp_trip_count}) begin
            nxt.heat_flag  = 1'b1;
            nxt.guard_mode = MODE_HEAT;
          end
        end else begin
          nxt.heat_run = '0;
        end
        if (nxt.heat_flag && (t_ext < tm_ext - TEMP_REL_OFS)) begin
          nxt.heat_flag  = 1'b0;
          nxt.guard_mode = MODE_NORMAL;
        end
      end
      CMD_SPEED: res.speed_reference = speed;
      default: ;
    endcase
    res.safe_state    = nxt.guard_mode;
    res.current_alarm = nxt.current_flag;
    res.heat_alarm    = nxt.heat_flag;
  end

endmodule

// File: design/motor_overload_derate_guard_core.sv
`timescale 1ns / 1ps
// Top level of the motor overload derate guard: registers, handshakes, config.
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_command, in_current_ma,      | receive
//          | in_temp_dc, in_speed_request                        |
//  out     | out_valid, out_stall, out_safe_state,               | send
//          | out_current_alarm, out_heat_alarm, out_speed_reference |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_wdata          | receive
//
// One transaction per cycle while out_stall is low; out_valid rises once an accepted input has passed
// an input register, then the guard update and derate multiply into the result register.
// Reset (rst_n low, synchronous) clears guard state, empties both stages and loads
// register defaults. out_stall holds the result register; the input register refills
// in the same cycle the result is taken. cfg_ready is always high.
module motor_overload_derate_guard_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_command,
  input  logic signed [mogd_pkg::CurWidth-1:0]   in_current_ma,
  input  logic signed [mogd_pkg::TempWidth-1:0]  in_temp_dc,
  input  logic signed [mogd_pkg::SpeedWidth-1:0] in_speed_request,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_safe_state,
  output logic                                   out_current_alarm,
  output logic                                   out_heat_alarm,
  output logic signed [mogd_pkg::SpeedWidth-1:0] out_speed_reference,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mogd_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [mogd_pkg::CfgDataWidth-1:0]      cfg_wdata
);
  import mogd_pkg::*;

  cfg_t         cfg_r;
  item_t        item_r;
  logic         item_valid_r;
  guard_state_t state_r;
  guard_state_t state_nxt;
  result_t      res_nxt;
  result_t      res_r;
  logic         out_valid_r;
  logic         advance;
  logic         in_take;

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = item_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_current_ma     <= MAX_CUR_RST;
      cfg_r.current_trip_count <= CUR_TRIP_RST;
      cfg_r.max_temp_dc        <= MAX_TEMP_RST;
      cfg_r.temp_trip_count    <= TEMP_TRIP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_CURRENT: cfg_r.max_current_ma     <= cfg_wdata[MaxCurWidth-1:0];
        REG_CUR_TRIP:    cfg_r.current_trip_count <= cfg_wdata[CountWidth-1:0];
        REG_MAX_TEMP:    cfg_r.max_temp_dc        <= cfg_wdata[TempWidth-1:0];
        REG_TEMP_TRIP:   cfg_r.temp_trip_count    <= cfg_wdata[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command       <= in_command;
      item_r.current_ma    <= in_current_ma;
      item_r.temp_dc       <= in_temp_dc;
      item_r.speed_request <= in_speed_request;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (advance || !item_valid_r) begin
      item_valid_r <= in_valid;
    end
  end

  mogd_eval u_eval (
    .cfg  (cfg_r),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
      if (item_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_safe_state      = res_r.safe_state;
  assign out_current_alarm   = res_r.current_alarm;
  assign out_heat_alarm      = res_r.heat_alarm;
  assign out_speed_reference = res_r.speed_reference;

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && advance) |=> out_valid_r)
    else $error("accepted transaction did not reach the result register");

  a_heat_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.safe_state == MODE_HEAT)) |-> (res_r.speed_reference == '0))
    else $error("nonzero speed reference in overtemperature stop");

  a_heat_trip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.heat_flag) |-> (state_r.guard_mode == MODE_HEAT))
    else $error("heat warning raised without overtemperature mode");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the motor overload derate guard: guard predictor, driver, monitor.
module tb_top;
  import mogd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int CUR_LO = -16000;
  localparam int CUR_HI = 16000;
  localparam int TEMP_LO = -400;
  localparam int TEMP_HI = 1500;
  localparam logic [CfgIdxWidth-1:0] REG_ORDER [4] =
    '{REG_MAX_CURRENT, REG_CUR_TRIP, REG_MAX_TEMP, REG_TEMP_TRIP};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_SPEED;
  logic signed [CurWidth-1:0] in_current_ma = '0;
  logic signed [TempWidth-1:0] in_temp_dc = '0;
  logic signed [SpeedWidth-1:0] in_speed_request = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_safe_state;
  logic out_current_alarm;
  logic out_heat_alarm;
  logic signed [SpeedWidth-1:0] out_speed_reference;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = REG_MAX_CURRENT;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  motor_overload_derate_guard_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_current_ma       (in_current_ma),
    .in_temp_dc          (in_temp_dc),
    .in_speed_request    (in_speed_request),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_safe_state      (out_safe_state),
    .out_current_alarm   (out_current_alarm),
    .out_heat_alarm      (out_heat_alarm),
    .out_speed_reference (out_speed_reference),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor copy of registers and guard state
  cfg_t guard_cfg = '{MAX_CUR_RST, CUR_TRIP_RST, MAX_TEMP_RST, TEMP_TRIP_RST};
  logic [RunWidth-1:0] cur_run = '0;
  logic [RunWidth-1:0] heat_run = '0;
  logic cur_flag = 1'b0;
  logic heat_flag = 1'b0;
  logic [1:0] guard_mode = MODE_NORMAL;
  logic [1:0] derate_sel = DERATE_DIV2;

  item_t cmd_queue [$];
  result_t status_due [$];
  item_t offered;
  int queued = 0;
  int gap_left = 0;
  int sent_count = 0;
  bit steady = 1'b0;
  int status_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int holds_done = 0;
  int run_left = 0;
  logic stall_level = 1'b0;
  logic stall_next;
  logic drive_next;

  function automatic result_t apply_command(input item_t it);
    result_t r;
    int c, m, lim, need, t, tmax, sp, rc;
    logic [1:0] code;
    bit hit;
    longint prod;
    r = '0;
    case (it.command)
      CMD_CURRENT: begin
        c = it.current_ma;
        m = int'(guard_cfg.max_current_ma);
        lim = int'(guard_cfg.current_trip_count);
        hit = 1'b1;
        need = 0;
        code = DERATE_DIV2;
        if (c > m) begin
          need = lim;
          code = DERATE_DIV2;
        end else if (c > m - TIER1_OFS) begin
          need = 2 * lim;
          code = DERATE_DIV1P5;
        end else if (c > m - TIER2_OFS) begin
          need = 3 * lim;
          code = DERATE_DIV1P25;
        end else begin
          hit = 1'b0;
        end
        if (hit) begin
          if (cur_run != RUN_MAX) cur_run = cur_run + 1'b1;
          if (int'(cur_run) >= need) begin
            cur_flag = 1'b1;
            guard_mode = MODE_DERATE;
            derate_sel = code;
          end
        end else begin
          cur_run = '0;
        end
        if (cur_flag && c < m - CUR_REL_OFS) begin
          cur_flag = 1'b0;
          guard_mode = MODE_NORMAL;
        end
      end
      CMD_TEMP: begin
        t = it.temp_dc;
        tmax = guard_cfg.max_temp_dc;
        if (t > tmax) begin
          if (heat_run != RUN_MAX) heat_run = heat_run + 1'b1;
          if (int'(heat_run) >= int'(guard_cfg.temp_trip_count)) begin
            heat_flag = 1'b1;
            guard_mode = MODE_HEAT;
          end
        end else begin
          heat_run = '0;
        end
        if (heat_flag && t < tmax - TEMP_REL_OFS) begin
          heat_flag = 1'b0;
          guard_mode = MODE_NORMAL;
        end
      end
      CMD_SPEED: begin
        sp = it.speed_request;
        if (guard_mode == MODE_HEAT) begin
          r.speed_reference = '0;
        end else if (guard_mode == MODE_DERATE) begin
          if (derate_sel == DERATE_DIV1P5) rc = RECIP_TWO_THIRDS;
          else if (derate_sel == DERATE_DIV1P25) rc = RECIP_FOUR_FIFTHS;
          else rc = RECIP_HALF;
          prod = longint'(sp) * longint'(rc);
          prod = prod >>> 16;
          r.speed_reference = prod[SpeedWidth-1:0];
        end else begin
          r.speed_reference = it.speed_request;
        end
      end
      default: begin
      end
    endcase
    r.safe_state = guard_mode;
    r.current_alarm = cur_flag;
    r.heat_alarm = heat_flag;
    return r;
  endfunction

  function automatic int pick(input int lo, input int hi, input int fl, input int cl);
    if (lo < fl) lo = fl;
    if (hi > cl) hi = cl;
    if (hi <= lo) return (lo > cl) ? cl : lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int current_in_band(input int band);
    int m;
    m = int'(guard_cfg.max_current_ma);
    case (band)
      0: return pick(m + 1, CUR_HI, CUR_LO, CUR_HI);
      1: return pick(m - 999, m, CUR_LO, CUR_HI);
      2: return pick(m - 1999, m - 1000, CUR_LO, CUR_HI);
      3: return pick(m - 2300, m - 2000, CUR_LO, CUR_HI);
      default: return pick(CUR_LO, m - 2301, CUR_LO, CUR_HI);
    endcase
  endfunction

  function automatic int temp_in_band(input int band);
    int tmax;
    tmax = guard_cfg.max_temp_dc;
    case (band)
      0: return pick(tmax + 1, TEMP_HI, TEMP_LO, TEMP_HI);
      1: return pick(tmax - 150, tmax, TEMP_LO, TEMP_HI);
      default: return pick(TEMP_LO, tmax - 151, TEMP_LO, TEMP_HI);
    endcase
  endfunction

  function automatic item_t noise_item();
    item_t it;
    int v;
    it.command = 2'($urandom_range(0, 3));
    v = int'($urandom_range(0, 32000)) - 16000;
    it.current_ma = CurWidth'(v);
    v = int'($urandom_range(0, 1900)) - 400;
    it.temp_dc = TempWidth'(v);
    it.speed_request = SpeedWidth'($urandom);
    return it;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input int value);
    item_t it;
    it = noise_item();
    it.command = cmd;
    case (cmd)
      CMD_CURRENT: it.current_ma = CurWidth'(value);
      CMD_TEMP: it.temp_dc = TempWidth'(value);
      CMD_SPEED: it.speed_request = SpeedWidth'(value);
      default: begin
      end
    endcase
    cmd_queue.push_back(it);
    queued++;
  endtask

  task automatic add_noise();
    cmd_queue.push_back(noise_item());
    queued++;
  endtask

  task automatic add_speed();
    add_item(CMD_SPEED, int'($urandom_range(0, 65535)) - 32768);
  endtask

  task automatic add_mixed(input bit is_temp, input int band);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (is_temp) add_item(CMD_TEMP, temp_in_band(band));
      else add_item(CMD_CURRENT, current_in_band(band));
    end else if (r < 90) begin
      add_speed();
    end else begin
      add_noise();
    end
  endtask

  task automatic add_segments(input int n);
    int stop, kind, len, lim, i;
    stop = queued + n;
    while (queued < stop) begin
      kind = $urandom_range(0, 8);
      case (kind)
        0, 1, 2: begin
          lim = int'(guard_cfg.current_trip_count);
          len = $urandom_range(1, ((kind + 1) * lim * 10) / 7 + 4);
          if (len > 120) len = $urandom_range(60, 120);
          for (i = 0; i < len; i++) add_mixed(1'b0, kind);
        end
        3: begin
          len = $urandom_range(1, 4);
          for (i = 0; i < len; i++) add_mixed(1'b0, $urandom_range(3, 4));
        end
        4: begin
          lim = int'(guard_cfg.temp_trip_count);
          len = $urandom_range(1, (lim * 10) / 7 + 4);
          if (len > 120) len = $urandom_range(60, 120);
          for (i = 0; i < len; i++) add_mixed(1'b1, 0);
        end
        5: begin
          len = $urandom_range(1, 4);
          for (i = 0; i < len; i++) add_mixed(1'b1, $urandom_range(1, 2));
        end
        6: begin
          len = $urandom_range(1, 6);
          for (i = 0; i < len; i++) add_speed();
        end
        7: begin
          len = $urandom_range(1, 4);
          for (i = 0; i < len; i++) add_noise();
        end
        default: begin
          add_item(CMD_CURRENT, current_in_band($urandom_range(0, 4)));
          add_item(CMD_TEMP, temp_in_band($urandom_range(0, 2)));
          add_speed();
        end
      endcase
    end
  endtask

  // sampled away from the rising edge so driver and monitor updates have settled
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    logic [CfgDataWidth-1:0] data [4];
    int i;
    data[0] = c.max_current_ma;
    data[1] = {6'($urandom), c.current_trip_count};
    data[2] = {2'($urandom), c.max_temp_dc};
    data[3] = {6'($urandom), c.temp_trip_count};
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ORDER[0];
    cfg_wdata <= data[0];
    for (i = 0; i < 4; i++) begin
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (REG_ORDER[i])
        REG_MAX_CURRENT: guard_cfg.max_current_ma = data[i][MaxCurWidth-1:0];
        REG_CUR_TRIP: guard_cfg.current_trip_count = data[i][CountWidth-1:0];
        REG_MAX_TEMP: guard_cfg.max_temp_dc = data[i][TempWidth-1:0];
        default: guard_cfg.temp_trip_count = data[i][CountWidth-1:0];
      endcase
      if (i < 3) begin
        cfg_index <= REG_ORDER[i+1];
        cfg_wdata <= data[i+1];
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  endtask

  function automatic cfg_t make_cfg(input int m, input int lc, input int t, input int lt);
    cfg_t c;
    c.max_current_ma = MaxCurWidth'(m);
    c.current_trip_count = CountWidth'(lc);
    c.max_temp_dc = TempWidth'(t);
    c.temp_trip_count = CountWidth'(lt);
    return c;
  endfunction

  task automatic run_phase(input cfg_t c, input int n);
    wait_idle();
    write_config(c);
    add_segments(n / 2);
    wait_idle();
    add_segments(n - n / 2);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d, %s: got %0d, expected %0d", status_seen, what, got, want);
    mismatches++;
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: passthrough, unused command, field extremes, tier and release edges
    add_item(CMD_SPEED, 32767);
    add_item(CMD_SPEED, -32768);
    add_item(CMD_SPEED, 0);
    add_item(CMD_SPEED, -1);
    add_item(2'd3, 0);
    add_item(CMD_CURRENT, CUR_HI);
    add_item(CMD_CURRENT, CUR_LO);
    add_item(CMD_CURRENT, 5001);
    add_item(CMD_CURRENT, 5000);
    add_item(CMD_CURRENT, 4001);
    add_item(CMD_CURRENT, 3001);
    add_item(CMD_CURRENT, 3000);
    add_item(CMD_CURRENT, 2699);
    add_item(CMD_TEMP, TEMP_HI);
    add_item(CMD_TEMP, TEMP_LO);
    add_item(CMD_TEMP, 701);
    add_item(CMD_TEMP, 700);
    add_item(CMD_TEMP, 549);
    add_segments(40);

    // low extremes, zero trip counts trip at once
    wait_idle();
    write_config(make_cfg(0, 0, TEMP_LO, 0));
    add_item(CMD_CURRENT, 1);
    add_item(CMD_SPEED, -32768);
    add_item(CMD_SPEED, 32767);
    add_item(CMD_CURRENT, 0);
    add_item(CMD_SPEED, 32767);
    add_item(CMD_SPEED, -32767);
    add_item(CMD_CURRENT, -1500);
    add_item(CMD_SPEED, -32768);
    add_item(CMD_TEMP, -399);
    add_item(CMD_SPEED, 12345);
    add_item(CMD_CURRENT, -2301);
    add_item(CMD_SPEED, 777);
    add_segments(30);

    run_phase(make_cfg(CUR_HI, 255, TEMP_HI, 255), 40);

    // long over-limit run drives the current counter into saturation
    wait_idle();
    write_config(make_cfg(8000, 255, 1000, 255));
    for (i = 0; i < 1030; i++) begin
      add_item(CMD_CURRENT, current_in_band(0));
      if (i % 16 == 15) add_speed();
    end
    add_item(CMD_CURRENT, current_in_band(2));
    add_speed();
    add_item(CMD_CURRENT, current_in_band(1));
    add_speed();
    add_item(CMD_CURRENT, current_in_band(4));
    add_item(CMD_TEMP, temp_in_band(0));
    add_speed();

    for (i = 0; i < 2; i++) begin
      run_phase(make_cfg($urandom_range(0, 16000), $urandom_range(1, 6),
                         int'($urandom_range(0, 1900)) - 400, $urandom_range(1, 6)), 60);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      drive_next = in_valid;
      if (in_valid && !in_stall) begin
        status_due.push_back(apply_command(offered));
        drive_next = 1'b0;
        sent_count++;
        if (sent_count % 128 == 0) steady = ($urandom_range(0, 3) == 0);
        if (steady) begin
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:64]: gap_left = 0;
            [65:87]: gap_left = $urandom_range(1, 3);
            [88:96]: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() != 0) begin
          offered = cmd_queue.pop_front();
          drive_next = 1'b1;
          in_command <= offered.command;
          in_current_ma <= offered.current_ma;
          in_temp_dc <= offered.temp_dc;
          in_speed_request <= offered.speed_request;
        end
      end
      in_valid <= drive_next;
    end
  end

  // result stall generator, with two long hold-offs while input is still pending
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (holds_done < 2 && cmd_queue.size() > 40 &&
                   status_seen >= 100 + holds_done * 500) begin
        hold_left = 250;
        holds_done++;
        stall_next = 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 99)) inside
            [0:54]: begin stall_level = 1'b0; run_left = $urandom_range(1, 12); end
            [55:69]: begin stall_level = 1'b0; run_left = $urandom_range(30, 120); end
            [70:91]: begin stall_level = 1'b1; run_left = $urandom_range(1, 3); end
            [92:97]: begin stall_level = 1'b1; run_left = $urandom_range(4, 12); end
            default: begin stall_level = 1'b1; run_left = $urandom_range(20, 60); end
          endcase
        end else begin
          run_left--;
        end
        stall_next = stall_level;
      end
      out_stall <= stall_next;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        flag_mismatch("result with no transaction pending", out_safe_state, 0);
      end else begin
        want = status_due.pop_front();
        if (out_safe_state !== want.safe_state)
          flag_mismatch("safe_state", out_safe_state, want.safe_state);
        if (out_current_alarm !== want.current_alarm)
          flag_mismatch("current_alarm", out_current_alarm, want.current_alarm);
        if (out_heat_alarm !== want.heat_alarm)
          flag_mismatch("heat_alarm", out_heat_alarm, want.heat_alarm);
        if (out_speed_reference !== want.speed_reference)
          flag_mismatch("speed_reference", out_speed_reference, want.speed_reference);
      end
      status_seen++;
    end
  end

endmodule
